>>> rtl/core/slr_pkg.sv
// Shared constants, widths and types of the speaker level to PCM resampler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package slr_pkg;

    localparam int FRAC_BITS = 24;

    localparam int LEVEL_W = 16;
    localparam int TICK_W  = 32;
    localparam int COUNT_W = 16;
    localparam int SPT_W   = 40;
    localparam int MAX_W   = 16;

    localparam int SPT_HALF     = SPT_W / 2;
    localparam int AMT_W        = MAX_W + FRAC_BITS;
    localparam int PLEN_W       = FRAC_BITS + 1;
    localparam int PSUM_W       = LEVEL_W + FRAC_BITS + 2;
    localparam int PROD_W       = TICK_W + SPT_W;
    localparam int CHUNK_PROD_W = TICK_W + SPT_HALF;

    localparam int MUL_A_W = TICK_W + 1;
    localparam int MUL_B_W = ((SPT_HALF > PLEN_W) ? SPT_HALF : PLEN_W) + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic [PLEN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'h8300;
    localparam logic [LEVEL_W-1:0] TOGGLE_MASK = 16'hFE00;

    localparam logic KIND_SET    = 1'b0;
    localparam logic KIND_TOGGLE = 1'b1;

    localparam logic REG_SPT = 1'b0;
    localparam logic REG_MAX = 1'b1;

    localparam logic [SPT_W-1:0] SPT_RESET = 40'd369098;
    localparam logic [MAX_W-1:0] MAX_RESET = 16'd4096;

    typedef struct packed {
        logic [SPT_W-1:0] spt;
        logic [MAX_W-1:0] max_run;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/slr_if.sv
// Stream interfaces of the resampler: speaker events in, PCM run packets out.
// Depends on slr_pkg for the field widths.
`default_nettype none

interface slr_event_if;
    import slr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [LEVEL_W-1:0] level;
    logic [TICK_W-1:0]         tick;

    modport source (output valid, kind, level, tick, input ready);
    modport sink (input valid, kind, level, tick, output ready);
endinterface

interface slr_packet_if;
    import slr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] sample_level;
    logic [COUNT_W-1:0]        sample_count;
    logic                      last_of_run;

    modport source (output valid, sample_level, sample_count, last_of_run, input ready);
    modport sink (input valid, sample_level, sample_count, last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/core/slr_mul.sv
// Shared signed multiplier of the resampler with a registered product.
// Depends on slr_pkg for the operand widths.
`default_nettype none

module slr_mul (
    input  logic                              clk,
    input  logic signed [slr_pkg::MUL_A_W-1:0] a,
    input  logic signed [slr_pkg::MUL_B_W-1:0] b,
    output logic signed [slr_pkg::MUL_P_W-1:0] product
);
    import slr_pkg::*;

    logic signed [MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign product = product_reg;

endmodule

`default_nettype wire

>>> rtl/core/slr_cfg.sv
// APB register file of the resampler: samples per tick and the run limit.
// Depends on slr_pkg for the register layout and reset values.
`default_nettype none

module slr_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [slr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [slr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output slr_pkg::cfg_t                   cfg
);
    import slr_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;
    logic reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spt     <= SPT_RESET;
            cfg_reg.max_run <= MAX_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_SPT)
            begin
                cfg_reg.spt <= pwdata[SPT_W-1:0];
            end
            else
            begin
                cfg_reg.max_run <= pwdata[MAX_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_MAX)
        begin
            prdata = APB_DATA_W'(cfg_reg.max_run);
        end
        else
        begin
            prdata = APB_DATA_W'(cfg_reg.spt);
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/speaker_level_to_pcm_resampler.sv
// Top level of the speaker level to PCM resampler: sequencer, state and output register.
// Depends on slr_pkg, slr_if, slr_mul and slr_cfg.
`default_nettype none

// Each accepted speaker event is worked through by a small sequencer that reuses one
// 33 by 26 bit multiplier: two passes form the elapsed ticks times samples per tick,
// one pass weights the level into a partly filled sample, and one pass starts the next
// partial sample. An event that only adds to the pending sample emits no packet, one that
// runs past the end of the pending sample emits its average, and one that covers more
// than a whole sample also emits a run; the sequencer waits while the sink holds back a
// packet. The event port is ready only between events, and the last packet of an event
// may wait in the output register while the next event is taken. Registers sit at byte
// addresses 0 and 8 of a 64-bit APB port.
module speaker_level_to_pcm_resampler (
    input  logic                            clk,
    input  logic                            rst_n,
    slr_event_if.sink                       spk,
    slr_packet_if.source                    pcm,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [slr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [slr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import slr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD,
        ST_CLAMP,
        ST_PEND,
        ST_ACCUM,
        ST_AVG,
        ST_EMIT_AVG,
        ST_WHOLE,
        ST_FRAC,
        ST_FIN
    } state_t;

    cfg_t cfg;

    state_t                    state_reg,     state_next;
    logic [LEVEL_W-1:0]        level_reg,     level_next;
    logic [TICK_W-1:0]         prev_tick_reg, prev_tick_next;
    logic [PLEN_W-1:0]         plen_reg,      plen_next;
    logic signed [PSUM_W-1:0]  psum_reg,      psum_next;
    logic [TICK_W-1:0]         tick_reg,      tick_next;
    logic [TICK_W-1:0]         delta_reg,     delta_next;
    logic                      special_reg,   special_next;
    logic [PROD_W-1:0]         acc_reg,       acc_next;
    logic [AMT_W-1:0]          amount_reg,    amount_next;
    logic                      out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]        out_level_reg, out_level_next;
    logic [COUNT_W-1:0]        out_count_reg, out_count_next;
    logic                      out_last_reg,  out_last_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] product;

    logic                      accept;
    logic                      slot_free;
    logic [AMT_W-1:0]          limit;
    logic                      too_big;
    logic [AMT_W:0]            pend_sum;
    logic                      crosses;
    logic [PLEN_W-1:0]         rest;
    logic [LEVEL_W-1:0]        new_level;
    logic signed [PSUM_W-1:0]  quot;
    logic                      adj;
    logic [LEVEL_W-1:0]        avg;

    slr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slr_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    assign accept    = spk.valid && spk.ready;
    assign slot_free = !out_valid_reg || pcm.ready;
    assign new_level = (spk.kind == KIND_TOGGLE) ? (level_reg ^ TOGGLE_MASK) : spk.level;

    assign limit    = {cfg.max_run, {FRAC_BITS{1'b0}}};
    assign too_big  = (acc_reg[PROD_W-1:AMT_W] != '0) || (acc_reg[AMT_W-1:0] > limit);
    assign pend_sum = {1'b0, amount_reg} + (AMT_W + 1)'(plen_reg);
    assign crosses  = pend_sum > (AMT_W + 1)'(ONE);
    assign rest     = ONE - plen_reg;

    assign quot = psum_reg >>> FRAC_BITS;
    assign adj  = psum_reg[PSUM_W-1] && (psum_reg[FRAC_BITS-1:0] != '0);
    assign avg  = quot[LEVEL_W-1:0] + LEVEL_W'(adj);

    always_comb
    begin
        case (state_reg)
            ST_MUL_LO:
            begin
                mul_a = {1'b0, delta_reg};
                mul_b = MUL_B_W'(cfg.spt[SPT_HALF-1:0]);
            end
            ST_MUL_HI:
            begin
                mul_a = {1'b0, delta_reg};
                mul_b = MUL_B_W'(cfg.spt[SPT_W-1:SPT_HALF]);
            end
            ST_PEND:
            begin
                mul_a = MUL_A_W'($signed(level_reg));
                mul_b = MUL_B_W'(crosses ? rest : amount_reg[PLEN_W-1:0]);
            end
            ST_FRAC:
            begin
                mul_a = MUL_A_W'($signed(level_reg));
                mul_b = MUL_B_W'(amount_reg[PLEN_W-1:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        prev_tick_next = prev_tick_reg;
        plen_next      = plen_reg;
        psum_next      = psum_reg;
        tick_next      = tick_reg;
        delta_next     = delta_reg;
        special_next   = special_reg;
        acc_next       = acc_reg;
        amount_next    = amount_reg;
        out_valid_next = out_valid_reg && !pcm.ready;
        out_level_next = out_level_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    level_next   = new_level;
                    tick_next    = spk.tick;
                    delta_next   = spk.tick - prev_tick_reg;
                    special_next = (spk.tick < prev_tick_reg) || (prev_tick_reg == '0);
                    state_next   = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                acc_next   = PROD_W'(product[CHUNK_PROD_W-1:0]);
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next   = acc_reg + (PROD_W'(product[CHUNK_PROD_W-1:0]) << SPT_HALF);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                amount_next = (special_reg || too_big) ? AMT_W'(ONE) : acc_reg[AMT_W-1:0];
                state_next  = ST_PEND;
            end
            ST_PEND:
            begin
                if (plen_reg == '0)
                begin
                    state_next = ST_WHOLE;
                end
                else if (crosses)
                begin
                    amount_next = amount_reg - AMT_W'(rest);
                    state_next  = ST_AVG;
                end
                else
                begin
                    plen_next  = plen_reg + amount_reg[PLEN_W-1:0];
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                psum_next      = psum_reg + PSUM_W'(product);
                prev_tick_next = tick_reg;
                state_next     = ST_IDLE;
            end
            ST_AVG:
            begin
                psum_next  = psum_reg + PSUM_W'(product);
                state_next = ST_EMIT_AVG;
            end
            ST_EMIT_AVG:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = avg;
                    out_count_next = COUNT_W'(1);
                    out_last_next  = !(amount_reg > AMT_W'(ONE));
                    plen_next      = '0;
                    psum_next      = '0;
                    state_next     = ST_WHOLE;
                end
            end
            ST_WHOLE:
            begin
                if (!(amount_reg > AMT_W'(ONE)))
                begin
                    state_next = ST_FRAC;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = level_reg;
                    out_count_next = amount_reg[AMT_W-1:FRAC_BITS];
                    out_last_next  = 1'b1;
                    amount_next    = {{MAX_W{1'b0}}, amount_reg[FRAC_BITS-1:0]};
                    state_next     = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                plen_next  = amount_reg[PLEN_W-1:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                psum_next      = PSUM_W'(product);
                prev_tick_next = tick_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= LEVEL_RESET;
            prev_tick_reg <= '0;
            plen_reg      <= '0;
            psum_reg      <= '0;
            tick_reg      <= '0;
            delta_reg     <= '0;
            special_reg   <= 1'b0;
            acc_reg       <= '0;
            amount_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_level_reg <= '0;
            out_count_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            prev_tick_reg <= prev_tick_next;
            plen_reg      <= plen_next;
            psum_reg      <= psum_next;
            tick_reg      <= tick_next;
            delta_reg     <= delta_next;
            special_reg   <= special_next;
            acc_reg       <= acc_next;
            amount_reg    <= amount_next;
            out_valid_reg <= out_valid_next;
            out_level_reg <= out_level_next;
            out_count_reg <= out_count_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign spk.ready        = (state_reg == ST_IDLE);
    assign pcm.valid        = out_valid_reg;
    assign pcm.sample_level = out_level_reg;
    assign pcm.sample_count = out_count_reg;
    assign pcm.last_of_run  = out_last_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MUL_LO)
        else $error("An accepted event did not start the multiply sequence.");

    a_partial_bound: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= ONE)
        else $error("The pending sample is longer than one sample.");

    a_amount_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PEND |-> (amount_reg <= limit || amount_reg == AMT_W'(ONE)))
        else $error("The sample amount escaped the run limit.");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pcm.valid |-> pcm.sample_count != '0)
        else $error("A packet carries a zero sample count.");

endmodule

`default_nettype wire
